/* hdl/stp_pkg.sv */
// ---------------------------------------------------------------------------
// stp_pkg: shared types and codes for the one-shot timer pool
// Command codes, slot status codes and the command record that goes from
// the front end to the back end.
// ---------------------------------------------------------------------------
package stp_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_POLL  = 2'd2,
    OP_STOP  = 2'd3
  } op_t;

  typedef logic [1:0] st_t;

  localparam st_t ST_FREE = 2'd0;
  localparam st_t ST_RUN  = 2'd1;
  localparam st_t ST_DONE = 2'd2;

  localparam int TICKS_W = 16;
  localparam int INDEX_W = 8;
  localparam int SLOT_W  = 4;

  typedef struct packed {
    op_t                op;
    logic [TICKS_W-1:0] ticks;
    logic [INDEX_W-1:0] index;
    logic               in_range;
  } cmd_t;

endpackage

/* hdl/stp_ifs.sv */
// ---------------------------------------------------------------------------
// stp_ifs: channel interfaces of the timer pool
// Valid/ready channels for commands in and results out.
// ---------------------------------------------------------------------------
interface stp_in_if;
  import stp_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [TICKS_W-1:0] ticks;
  logic [INDEX_W-1:0] index;

  modport source (output valid, output op, output ticks, output index, input ready);
  modport sink   (input valid, input op, input ticks, input index, output ready);
endinterface

interface stp_out_if;
  import stp_pkg::*;

  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] slot;
  logic              expired;

  modport source (output valid, output slot, output expired, input ready);
  modport sink   (input valid, input slot, input expired, output ready);
endinterface

/* hdl/software_timer_pool.sv */
// ---------------------------------------------------------------------------
// software_timer_pool: pool of one-shot countdown timers
// Start/poll/stop: result registered on transfer; one command a cycle while
// idle with room. Tick: sweeps one slot a cycle (last waits), result at end.
// ---------------------------------------------------------------------------
// Synchronous active-low reset frees all slots; counts are loaded by start.
module software_timer_pool #(
  parameter int TIMER_COUNT = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  stp_in_if.sink    in_ch,
  stp_out_if.source out_ch
);
  import stp_pkg::*;

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  stp_front #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  stp_back #(
    .TIMER_COUNT (TIMER_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_ch    (out_ch)
  );

`ifndef SYNTH
  // out-of-range poll reports expired on the next cycle
  a_poll_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready && (cmd.op == OP_POLL) && !cmd.in_range)
      |=> (out_ch.valid && out_ch.expired))
    else $error("out-of-range poll did not report expired");

  // start result comes out next cycle with expired clear
  a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready && (cmd.op == OP_START))
      |=> (out_ch.valid && !out_ch.expired))
    else $error("start result missing");

  // intake only backs up when the queue holds work
  a_queue_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_ch.ready) |-> cmd_valid)
    else $error("intake stalled with empty queue");
`endif

endmodule

/* hdl/stp_front.sv */
// ---------------------------------------------------------------------------
// stp_front: command intake of the timer pool
// Takes commands, checks the slot index range and holds them in a
// two-entry queue for the back end.
// ---------------------------------------------------------------------------
module stp_front #(
  parameter int TIMER_COUNT = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  stp_in_if.sink        in_ch,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output stp_pkg::cmd_t cmd
);
  import stp_pkg::*;

  localparam int QDEPTH = 2;

  cmd_t       q_r [QDEPTH];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  cmd_t       in_cmd;
  logic       push;
  logic       pop;

  always_comb begin
    in_cmd.op       = op_t'(in_ch.op);
    in_cmd.ticks    = in_ch.ticks;
    in_cmd.index    = in_ch.index;
    in_cmd.in_range = ({1'b0, in_ch.index} < (INDEX_W+1)'(TIMER_COUNT));
  end

  assign in_ch.ready = (cnt_r != 2'(QDEPTH));
  assign cmd_valid   = (cnt_r != 2'd0);
  assign cmd         = q_r[rd_ptr_r];
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = cmd_valid && cmd_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

endmodule

/* hdl/stp_back.sv */
// ---------------------------------------------------------------------------
// stp_back: execution engine of the timer pool
// Holds slot status and countdown memory, runs commands and drives the
// result register. A tick sweeps one slot per cycle; the last waits for room.
// ---------------------------------------------------------------------------
module stp_back #(
  parameter int TIMER_COUNT = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  stp_pkg::cmd_t cmd,
  stp_out_if.source     out_ch
);
  import stp_pkg::*;

  localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic               state_r;
  logic [IW-1:0]      cnt_r;
  st_t                status_r [TIMER_COUNT];
  logic [TICKS_W-1:0] rem_mem [TIMER_COUNT];
  logic [TICKS_W-1:0] rd_data_r;
  logic [TICKS_W-1:0] dec;
  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      wr_addr;
  logic [TICKS_W-1:0] wr_data;
  logic               wr_en;

  logic               out_valid_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic               out_exp_r;
  logic [SLOT_W-1:0]  slot_nxt;
  logic               exp_nxt;
  logic               load;

  logic               accept;
  logic               out_free;
  logic               last;
  logic               scan_step;
  logic               scan_run;
  logic               free_found;
  logic [IW-1:0]      free_idx;
  logic [IW-1:0]      cmd_idx;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign cmd_ready = (state_r == S_IDLE) && out_free;
  assign accept    = cmd_valid && cmd_ready;
  assign last      = (cnt_r == IW'(TIMER_COUNT - 1));
  // the final slot of a sweep also writes the result, so it waits for room
  assign scan_step = (state_r == S_SCAN) && (!last || out_free);
  assign scan_run  = scan_step && (status_r[cnt_r] == ST_RUN);
  assign dec       = rd_data_r - TICKS_W'(1);
  assign cmd_idx   = cmd.index[IW-1:0];

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int k = TIMER_COUNT - 1; k >= 0; k--) begin
      if (status_r[k] == ST_FREE) begin
        free_found = 1'b1;
        free_idx   = IW'(k);
      end
    end
  end

  always_comb begin
    if (state_r == S_IDLE) begin
      rd_addr = '0;
    end else if (!scan_step) begin
      rd_addr = cnt_r;
    end else if (last) begin
      rd_addr = '0;
    end else begin
      rd_addr = cnt_r + IW'(1);
    end
  end

  always_comb begin
    wr_en   = scan_run || (accept && (cmd.op == OP_START) && free_found);
    wr_addr = (state_r == S_SCAN) ? cnt_r : free_idx;
    wr_data = (state_r == S_SCAN) ? dec : cmd.ticks;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rem_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= rem_mem[rd_addr];
  end

  always_comb begin
    slot_nxt = '0;
    exp_nxt  = 1'b0;
    load     = scan_step && last;
    if (accept) begin
      unique case (cmd.op)
        OP_TICK: begin
          load = 1'b0;
        end
        OP_START: begin
          load     = 1'b1;
          slot_nxt = free_found ? SLOT_W'(free_idx) : SLOT_W'(TIMER_COUNT);
        end
        OP_POLL: begin
          load    = 1'b1;
          exp_nxt = !cmd.in_range || (status_r[cmd_idx] == ST_DONE);
        end
        OP_STOP: begin
          load = 1'b1;
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      for (int k = 0; k < TIMER_COUNT; k++) begin
        status_r[k] <= ST_FREE;
      end
    end else begin
      if (accept) begin
        unique case (cmd.op)
          OP_TICK: begin
            state_r <= S_SCAN;
            cnt_r   <= '0;
          end
          OP_START: begin
            if (free_found) begin
              status_r[free_idx] <= ST_RUN;
            end
          end
          OP_POLL: begin
            if (cmd.in_range && (status_r[cmd_idx] == ST_DONE)) begin
              status_r[cmd_idx] <= ST_FREE;
            end
          end
          OP_STOP: begin
            if (cmd.in_range) begin
              status_r[cmd_idx] <= ST_FREE;
            end
          end
          default: begin
          end
        endcase
      end
      if (scan_step) begin
        cnt_r <= cnt_r + IW'(1);
        if (last) begin
          state_r <= S_IDLE;
        end
      end
      if (scan_run && (dec == '0)) begin
        status_r[cnt_r] <= ST_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_slot_r <= slot_nxt;
      out_exp_r  <= exp_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.slot    = out_slot_r;
  assign out_ch.expired = out_exp_r;

endmodule

/* verif/stp_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stp_checker: reply checker for the one-shot timer pool
// Keeps its own copy of slot counts and status, updates it on every command
// transfer and compares each reply transfer, field by field, in order.
// ---------------------------------------------------------------------------
module stp_checker #(
  parameter int TIMER_COUNT = 8
) (
  input  logic clk,
  input  logic rst_n,
  stp_in_if    in_ch,
  stp_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  import stp_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              expired;
  } reply_t;

  logic [TICKS_W-1:0] count_left [TIMER_COUNT];
  st_t                slot_state [TIMER_COUNT];
  reply_t             replies_due [$];
  reply_t             want;

  function automatic reply_t predict_reply(op_t op, logic [TICKS_W-1:0] len,
                                           logic [INDEX_W-1:0] idx);
    reply_t r;
    bit     found;
    r     = '0;
    found = 1'b0;
    case (op)
      OP_TICK: begin
        for (int k = 0; k < TIMER_COUNT; k++) begin
          if (slot_state[k] == ST_RUN) begin
            // a zero load wraps to all ones here
            count_left[k] = count_left[k] - 1'b1;
            if (count_left[k] == '0) slot_state[k] = ST_DONE;
          end
        end
      end
      OP_START: begin
        r.slot = SLOT_W'(TIMER_COUNT);
        for (int k = 0; k < TIMER_COUNT; k++) begin
          if (!found && slot_state[k] == ST_FREE) begin
            count_left[k] = len;
            slot_state[k] = ST_RUN;
            r.slot        = SLOT_W'(k);
            found         = 1'b1;
          end
        end
      end
      OP_POLL: begin
        if (idx >= TIMER_COUNT) begin
          r.expired = 1'b1;
        end else if (slot_state[idx] == ST_DONE) begin
          slot_state[idx] = ST_FREE;
          r.expired       = 1'b1;
        end
      end
      OP_STOP: begin
        if (idx < TIMER_COUNT) slot_state[idx] = ST_FREE;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TIMER_COUNT; k++) slot_state[k] = ST_FREE;
      replies_due.delete();
      fail_count = 0;
    end else begin
      // replies trail commands through the queue and result register, so check the reply first
      if (out_ch.valid && out_ch.ready) begin
        if (replies_due.size() == 0) begin
          $error("unexpected reply transfer: slot %0d expired %0b",
                 out_ch.slot, out_ch.expired);
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          if (out_ch.slot !== want.slot) begin
            $error("slot mismatch: expected %0d, got %0d", want.slot, out_ch.slot);
            fail_count++;
          end
          if (out_ch.expired !== want.expired) begin
            $error("expired mismatch: expected %0b, got %0b", want.expired,
                   out_ch.expired);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        replies_due.push_back(predict_reply(op_t'(in_ch.op), in_ch.ticks, in_ch.index));
      end
    end
    pending = replies_due.size();
  end

endmodule

/* verif/tb_software_timer_pool.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_software_timer_pool: testbench top for the one-shot timer pool
// Directed commands for free, running, expired and out-of-range slots, then
// random command streams under three idle/stall patterns.
// ---------------------------------------------------------------------------
module tb_software_timer_pool;
  import stp_pkg::*;

  localparam int TIMER_COUNT    = 8;
  localparam int RAND_PER_PHASE = 170;
  localparam int DRAIN_CYCLES   = 2 * (TIMER_COUNT + 2);

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   fail_count;
  int   pending;

  stp_in_if  in_ch ();
  stp_out_if out_ch ();

  software_timer_pool #(
    .TIMER_COUNT(TIMER_COUNT)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  stp_checker #(
    .TIMER_COUNT(TIMER_COUNT)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_cmd(input op_t op, input logic [TICKS_W-1:0] len,
                          input logic [INDEX_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.ticks <= len;
    in_ch.index <= idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random();
    int                 pick;
    op_t                op;
    logic [TICKS_W-1:0] len;
    logic [INDEX_W-1:0] idx;
    pick = $urandom_range(99);
    if (pick < 35)      op = OP_TICK;
    else if (pick < 60) op = OP_START;
    else if (pick < 85) op = OP_POLL;
    else                op = OP_STOP;
    // mostly short countdowns so that slots expire and get reused
    pick = $urandom_range(99);
    if (pick < 70)      len = TICKS_W'($urandom_range(6, 1));
    else if (pick < 90) len = TICKS_W'($urandom);
    else begin
      case ($urandom_range(2))
        0:       len = '0;
        1:       len = TICKS_W'(1);
        default: len = '1;
      endcase
    end
    if ($urandom_range(99) < 85) idx = INDEX_W'($urandom_range(TIMER_COUNT - 1));
    else                         idx = INDEX_W'($urandom);
    send_cmd(op, len, idx);
  endtask

  // hold the sender off until every reply is back
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.op       = OP_TICK;
    in_ch.ticks    = '0;
    in_ch.index    = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 25;
    recv_stall_pct = 81;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // empty pool: free slot, out-of-range polls and stops
    send_cmd(OP_POLL, 16'h0000, 8'd0);
    send_cmd(OP_POLL, 16'hFFFF, 8'd255);
    send_cmd(OP_POLL, 16'h0000, 8'(TIMER_COUNT));
    send_cmd(OP_STOP, 16'h0000, 8'd255);
    send_cmd(OP_STOP, 16'h0000, 8'd0);
    // longest, zero (wraps), one and two ticks
    send_cmd(OP_START, 16'hFFFF, 8'd0);
    send_cmd(OP_START, 16'h0000, 8'd0);
    send_cmd(OP_START, 16'h0001, 8'd0);
    send_cmd(OP_START, 16'h0002, 8'd0);
    send_cmd(OP_TICK, 16'h0000, 8'd0);
    send_cmd(OP_POLL, 16'h0000, 8'd2);
    send_cmd(OP_POLL, 16'h0000, 8'd2);
    send_cmd(OP_POLL, 16'h0000, 8'd1);
    send_cmd(OP_POLL, 16'h0000, 8'd3);
    send_cmd(OP_TICK, 16'h0000, 8'd0);
    // stop on an expired slot frees it without a poll
    send_cmd(OP_STOP, 16'h0000, 8'd3);
    send_cmd(OP_POLL, 16'h0000, 8'd3);
    // fill the pool, then one start too many
    for (int n = 0; n < TIMER_COUNT - 1; n++) send_cmd(OP_START, 16'h0003, 8'd0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 25;
          recv_stall_pct = 81;
        end
        1: begin
          send_idle_pct  = 81;
          recv_stall_pct = 25;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (RAND_PER_PHASE) send_random();
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
